@@ rtl/point_cloud_height_grid_binning_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the height grid binning block.
// Checks can be removed from a build by defining NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef POINT_CLOUD_HEIGHT_GRID_BINNING_MACROS_SVH
`define POINT_CLOUD_HEIGHT_GRID_BINNING_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define PHGB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("phgb assertion failed");
// Checked on every clock edge, reset included.
`define PHGB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("phgb reset assertion failed");
`else
`define PHGB_ASSERT(lbl, prop)
`define PHGB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/phgb_pkg.sv @@
// ---------------------------------------------------------------------------
// phgb_pkg
// Shared types and constants of the height grid binning block.
// ---------------------------------------------------------------------------
package phgb_pkg;

  // Item commands.
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_POINT = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CELL_SIZE  = 3'd0;
  localparam logic [2:0] CFG_LAT_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_COLUMNS    = 3'd2;
  localparam logic [2:0] CFG_ROWS       = 3'd3;
  localparam logic [2:0] CFG_HEIGHT_LIM = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [30:0] RST_CELL_SIZE = 31'd3277;
  localparam logic [30:0] RST_LAT_WIDTH = 31'd196608;
  localparam logic [13:0] RST_COLUMNS   = 14'd100;
  localparam logic [13:0] RST_ROWS      = 14'd60;

  localparam int unsigned NUM_COEFS = 12;
  localparam logic [19:0] COUNT_MAX = 20'hFFFFF;
  localparam logic signed [31:0] Q16_ONE = 32'sh0001_0000;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_ACC, S_CHK, S_DIVX, S_DIVY, S_FLAT,
    S_ADDR, S_UPD, S_TOT, S_RANGE, S_MEAN, S_DIVM, S_EMIT
  } state_t;

  // Divider request and status.
  typedef struct packed {
    logic start;
    logic long_mode;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

@@ rtl/point_cloud_height_grid_binning.sv @@
// ---------------------------------------------------------------------------
// point_cloud_height_grid_binning
// Bins transformed points into a mean-height grid and reads cells back.
// ---------------------------------------------------------------------------
// Usage: each input transfer carries one command (clear, coefficient load,
// point or cell read); every command yields exactly one result transfer.
// The configuration port is to be written only while the block is idle; the block itself does not enforce this.
// Work per item, from the input transfer to the earliest result transfer
// (also the earliest next input transfer), done on the shared multiplier and
// the bit-serial divider:
//   coefficient load: a coefficient register write;
//   point: rejected early, rejected on the lateral check, or binned
//   (twelve multiply/add pairs, two 14-bit
//   divisions, index multiply, cell read-modify-write);
//   cell read: index multiply, cell read, 32-bit division;
//   clear: all MAX_CELLS cells, one cell per cycle.
// After reset the block runs the same clearing pass over all MAX_CELLS cells
// with in_stall high. in_stall is high whenever an item is in progress.
// A finished result sits in the output register until taken; while
// out_stall holds it, the next item may be accepted and worked on but
// its result waits.
// ---------------------------------------------------------------------------
`include "point_cloud_height_grid_binning_macros.svh"

module point_cloud_height_grid_binning #(
  parameter int MAX_CELLS = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [3:0]         in_coef_index,
  input  logic signed [31:0] in_coef_value,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic               in_point_finite,
  input  logic [12:0]        in_cell_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_point_binned,
  output logic               out_cell_filled,
  output logic signed [31:0] out_mean_height,
  output logic [19:0]        out_cell_count
);
  import phgb_pkg::*;

  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam logic [31:0] CELLS = 32'(MAX_CELLS);

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [30:0]        cell_size_r, lat_w_r;
  logic [13:0]        cols_r, rows_r;
  logic signed [31:0] hlim_r;

  // Item and working registers.
  logic signed [31:0] coef_r [NUM_COEFS];
  logic signed [31:0] px_r, py_r, pz_r;
  logic [12:0]        idx_r;
  logic [1:0]         crow_r, ccol_r;
  logic signed [51:0] acc_r, x_r, y_r, z_r;
  logic [13:0]        ix_r, iy_r;
  logic [AW-1:0]      addr_r, clr_r;
  logic               clr_emit_r, sum_neg_r;
  logic               res_binned_r, res_filled_r;
  logic signed [31:0] res_mean_r;
  logic [19:0]        res_count_r;

  // Output register.
  logic               out_valid_r, out_binned_r, out_filled_r;
  logic signed [31:0] out_mean_r;
  logic [19:0]        out_count_r;

  // Shared units.
  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  div_req_t           div_req;
  div_stat_t          div_stat;
  logic [51:0]        div_n;
  logic [32:0]        div_d;
  logic [31:0]        div_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [71:0]        mem_wdata, mem_rdata;

  // Combinational helpers.
  logic               in_xfer, out_free;
  logic [30:0]        cs_eff;
  logic signed [52:0] y2, wext;
  logic               win_ok, x_pos;
  logic [52:0]        ny;
  logic [28:0]        flat;
  logic [27:0]        total, src;
  logic               read_ok;
  logic signed [51:0] rd_sum, z_add, sum_new;
  logic [19:0]        rd_cnt;
  logic signed [31:0] z_sat;
  logic [51:0]        sum_mag;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  assign cs_eff  = (cell_size_r == 31'd0) ? 31'd1 : cell_size_r;
  assign y2      = {y_r, 1'b0};
  assign wext    = $signed({22'd0, lat_w_r});
  assign win_ok  = !(y2 < -wext) && (y2 < wext);
  assign x_pos   = x_r > 52'sd0;
  assign ny      = 53'(y2 + wext);
  assign flat    = prod[28:0] + {15'd0, ix_r};
  assign total   = prod[27:0];
  assign src     = total - 28'd1 - {15'd0, idx_r};
  assign read_ok = ({15'd0, idx_r} < total) && ({4'd0, src} < CELLS);
  assign rd_sum  = $signed(mem_rdata[71:20]);
  assign rd_cnt  = mem_rdata[19:0];
  assign sum_mag = rd_sum[51] ? 52'(-rd_sum) : 52'(rd_sum);

  // Map z saturated to the signed 32-bit range.
  always_comb begin
    if (z_r > 52'sh7FFF_FFFF) begin
      z_sat = 32'sh7FFF_FFFF;
    end else if (z_r < -52'sh8000_0000) begin
      z_sat = 32'sh8000_0000;
    end else begin
      z_sat = z_r[31:0];
    end
  end
  assign z_add   = 52'(z_sat);
  assign sum_new = rd_sum + z_add;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(MAX_CELLS - 1)) begin
          state_nxt = clr_emit_r ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (in_cmd)
            CMD_CLEAR: state_nxt = S_CLEAR;
            CMD_LOAD:  state_nxt = S_EMIT;
            CMD_POINT: begin
              if (!in_point_finite || (hlim_r > 32'sd0 && in_point_z >= hlim_r)) begin
                state_nxt = S_EMIT;
              end else begin
                state_nxt = S_MUL;
              end
            end
            default:   state_nxt = S_TOT;
          endcase
        end
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        if (ccol_r == 2'd3 && crow_r == 2'd2) begin
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_CHK:  state_nxt = (x_pos && win_ok) ? S_DIVX : S_EMIT;
      S_DIVX: begin
        if (div_stat.done) begin
          state_nxt = (!div_stat.ovf && div_q[13:0] < cols_r) ? S_DIVY : S_EMIT;
        end
      end
      S_DIVY: begin
        if (div_stat.done) begin
          state_nxt = (!div_stat.ovf && div_q[13:0] < rows_r) ? S_FLAT : S_EMIT;
        end
      end
      S_FLAT:  state_nxt = S_ADDR;
      S_ADDR:  state_nxt = ({3'd0, flat} < CELLS) ? S_UPD : S_EMIT;
      S_UPD:   state_nxt = S_EMIT;
      S_TOT:   state_nxt = S_RANGE;
      S_RANGE: state_nxt = read_ok ? S_MEAN : S_EMIT;
      S_MEAN:  state_nxt = (rd_cnt != 20'd0) ? S_DIVM : S_EMIT;
      S_DIVM:  state_nxt = div_stat.done ? S_EMIT : S_DIVM;
      S_EMIT:  state_nxt = out_free ? S_IDLE : S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Unit controls for the current state.
  always_comb begin
    mul_en            = 1'b0;
    mul_a             = coef_r[{crow_r, ccol_r}];
    mul_b             = Q16_ONE;
    div_req.start     = 1'b0;
    div_req.long_mode = 1'b0;
    div_n             = x_r[51:0];
    div_d             = {2'd0, cs_eff};
    mem_we            = 1'b0;
    mem_waddr         = clr_r;
    mem_wdata         = '0;
    mem_re            = 1'b0;
    mem_raddr         = flat[AW-1:0];
    case (state_r)
      S_CLEAR: mem_we = 1'b1;
      S_MUL: begin
        mul_en = 1'b1;
        case (ccol_r)
          2'd0:    mul_b = px_r;
          2'd1:    mul_b = py_r;
          2'd2:    mul_b = pz_r;
          default: mul_b = Q16_ONE;
        endcase
      end
      S_CHK: div_req.start = x_pos && win_ok;
      S_DIVX: begin
        div_n         = ny[51:0];
        div_d         = {1'b0, cs_eff, 1'b0};
        div_req.start = div_stat.done && !div_stat.ovf && div_q[13:0] < cols_r;
      end
      S_FLAT: begin
        mul_en = 1'b1;
        mul_a  = $signed({18'd0, iy_r});
        mul_b  = $signed({18'd0, cols_r});
      end
      S_ADDR: mem_re = {3'd0, flat} < CELLS;
      S_UPD: begin
        mem_we    = rd_cnt < COUNT_MAX;
        mem_waddr = addr_r;
        mem_wdata = {sum_new, rd_cnt + 20'd1};
      end
      S_TOT: begin
        mul_en = 1'b1;
        mul_a  = $signed({18'd0, cols_r});
        mul_b  = $signed({18'd0, rows_r});
      end
      S_RANGE: begin
        mem_re    = read_ok;
        mem_raddr = src[AW-1:0];
      end
      S_MEAN: begin
        div_n             = sum_mag;
        div_d             = {13'd0, rd_cnt};
        div_req.long_mode = 1'b1;
        div_req.start     = rd_cnt != 20'd0;
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      clr_emit_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cell_size_r <= RST_CELL_SIZE;
      lat_w_r     <= RST_LAT_WIDTH;
      cols_r      <= RST_COLUMNS;
      rows_r      <= RST_ROWS;
      hlim_r      <= '0;
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= (clr_r == AW'(MAX_CELLS - 1)) ? '0 : clr_r + AW'(1);
      end
      if (in_xfer) begin
        clr_emit_r <= in_cmd == CMD_CLEAR;
        if (in_cmd == CMD_LOAD && in_coef_index < 4'(NUM_COEFS)) begin
          coef_r[in_coef_index] <= in_coef_value;
        end
      end
      // Output register: a result enters when the register is free.
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // Configuration writes.
      if (cfg_we) begin
        case (cfg_index)
          CFG_CELL_SIZE:  cell_size_r <= cfg_wdata[30:0];
          CFG_LAT_WIDTH:  lat_w_r     <= cfg_wdata[30:0];
          CFG_COLUMNS:    cols_r      <= cfg_wdata[13:0];
          CFG_ROWS:       rows_r      <= cfg_wdata[13:0];
          CFG_HEIGHT_LIM: hlim_r      <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        px_r         <= in_point_x;
        py_r         <= in_point_y;
        pz_r         <= in_point_z;
        idx_r        <= in_cell_index;
        crow_r       <= 2'd0;
        ccol_r       <= 2'd0;
        res_binned_r <= 1'b0;
        res_filled_r <= 1'b0;
        res_mean_r   <= '0;
        res_count_r  <= '0;
      end
      S_ACC: begin
        // Each product floored on its own; the last column adds the offset.
        if (ccol_r == 2'd3) begin
          case (crow_r)
            2'd0:    x_r <= acc_r + 52'(prod >>> 16);
            2'd1:    y_r <= acc_r + 52'(prod >>> 16);
            default: z_r <= acc_r + 52'(prod >>> 16);
          endcase
          acc_r  <= '0;
          crow_r <= crow_r + 2'd1;
        end else if (ccol_r == 2'd0) begin
          acc_r <= 52'(prod >>> 16);
        end else begin
          acc_r <= acc_r + 52'(prod >>> 16);
        end
        ccol_r <= ccol_r + 2'd1;
      end
      S_DIVX: if (div_stat.done) ix_r <= div_q[13:0];
      S_DIVY: if (div_stat.done) iy_r <= div_q[13:0];
      S_ADDR: addr_r <= flat[AW-1:0];
      S_UPD:  res_binned_r <= rd_cnt < COUNT_MAX;
      S_MEAN: begin
        sum_neg_r    <= rd_sum[51];
        res_filled_r <= rd_cnt != 20'd0;
        res_count_r  <= rd_cnt;
      end
      S_DIVM: begin
        if (div_stat.done) begin
          res_mean_r <= sum_neg_r ? -$signed(div_q) : $signed(div_q);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_binned_r <= res_binned_r;
          out_filled_r <= res_filled_r;
          out_mean_r   <= res_mean_r;
          out_count_r  <= res_count_r;
        end
      end
      default: ;
    endcase
  end

  phgb_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  phgb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .n_i   (div_n),
    .d_i   (div_d),
    .stat  (div_stat),
    .q_o   (div_q)
  );

  phgb_bins #(
    .DEPTH (MAX_CELLS),
    .AW    (AW)
  ) u_bins (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_point_binned = out_binned_r;
  assign out_cell_filled  = out_filled_r;
  assign out_mean_height  = out_mean_r;
  assign out_cell_count   = out_count_r;

  // Reset always starts the clearing pass.
  `PHGB_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> state_r == S_CLEAR)
  // The divider only finishes while the sequencer waits for it.
  `PHGB_ASSERT(a_div_done_wait,
    div_stat.done |-> (state_r == S_DIVX || state_r == S_DIVY || state_r == S_DIVM))
  // A filled cell always reports a nonzero count.
  `PHGB_ASSERT(a_filled_count, out_valid_r && out_cell_filled |-> out_cell_count != 20'd0)
  // A binned point never carries read data.
  `PHGB_ASSERT(a_binned_no_read, out_valid_r && out_point_binned |-> !out_cell_filled)
endmodule

@@ rtl/phgb_mul.sv @@
// ---------------------------------------------------------------------------
// phgb_mul
// Shared signed 32x32 multiplier with a registered product.
// ---------------------------------------------------------------------------
module phgb_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);
  logic signed [63:0] prod_r;

  // The product is taken only when the sequencer issues one.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;
endmodule

@@ rtl/phgb_div.sv @@
// ---------------------------------------------------------------------------
// phgb_div
// Restoring divider, one quotient bit per cycle, 14 or 32 quotient bits.
// ---------------------------------------------------------------------------
module phgb_div (
  input  logic                clk,
  input  logic                rst_n,
  input  phgb_pkg::div_req_t  req,
  input  logic [51:0]         n_i,
  input  logic [32:0]         d_i,
  output phgb_pkg::div_stat_t stat,
  output logic [31:0]         q_o
);
  import phgb_pkg::*;

  logic        busy_r, done_r, ovf_r;
  logic [32:0] rem_r, d_r;
  logic [31:0] low_r, q_r;
  logic [4:0]  cnt_r;
  logic [33:0] trial;
  logic        ge;
  logic [51:0] n_hi;

  // Dividend bits above the quotient range; they must stay below the divisor.
  assign n_hi  = req.long_mode ? (n_i >> 32) : (n_i >> 14);
  assign trial = {rem_r, low_r[31]};
  assign ge    = trial >= {1'b0, d_r};

  // Control: busy flag, step count and the one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.long_mode ? 5'd31 : 5'd13;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: one compare and subtract a cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      d_r   <= d_i;
      ovf_r <= n_hi >= {19'd0, d_i};
      rem_r <= n_hi[32:0];
      low_r <= req.long_mode ? n_i[31:0] : {n_i[13:0], 18'd0};
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 33'(trial - {1'b0, d_r}) : trial[32:0];
      low_r <= {low_r[30:0], 1'b0};
      q_r   <= {q_r[30:0], ge};
    end
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign q_o       = q_r;
endmodule

@@ rtl/phgb_bins.sv @@
// ---------------------------------------------------------------------------
// phgb_bins
// Cell store: 52-bit height sum and 20-bit count per cell, registered read.
// ---------------------------------------------------------------------------
module phgb_bins #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [71:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [71:0]   rd_data
);
  logic [71:0] mem [DEPTH];
  logic [71:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule
